/* hdl/base64_line_wrapped_encoder_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the line-wrapped base64 encoder.
// ----------------------------------------------------------------------------
`ifndef BASE64_LINE_WRAPPED_ENCODER_MACROS_SVH
`define BASE64_LINE_WRAPPED_ENCODER_MACROS_SVH

// Check a property on every clock edge outside reset.
`define B64LW_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check a property on every clock edge, reset included.
`define B64LW_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hdl/b64lw_pkg.sv */
// ----------------------------------------------------------------------------
// b64lw_pkg
// Types, constants and character functions of the line-wrapped base64 encoder.
// ----------------------------------------------------------------------------
package b64lw_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [4:0] GROUPS_PER_LINE_RESET = 5'd19;

    localparam logic [7:0] CHAR_PAD     = 8'h3D;
    localparam logic [7:0] CHAR_CR      = 8'h0D;
    localparam logic [7:0] CHAR_LF      = 8'h0A;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;

    // Character slots within one group
    localparam logic [2:0] SLOT_SYM0 = 3'd0;
    localparam logic [2:0] SLOT_SYM1 = 3'd1;
    localparam logic [2:0] SLOT_SYM2 = 3'd2;
    localparam logic [2:0] SLOT_SYM3 = 3'd3;
    localparam logic [2:0] SLOT_CR   = 3'd4;
    localparam logic [2:0] SLOT_LF   = 3'd5;

    typedef struct packed {
        logic [1:0] nbytes;   // 1..3 bytes carried
        logic [7:0] e0;
        logic [7:0] e1;
        logic [7:0] e2;
        logic       crlf;     // line break follows this group
        logic       last;     // group closes the stream
    } group_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    function automatic logic [7:0] b64_symbol(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        if (v < 6'd26)
            return CHAR_UPPER_A + w;
        else if (v < 6'd52)
            return CHAR_LOWER_A + (w - 8'd26);
        else if (v < 6'd62)
            return CHAR_DIGIT_0 + (w - 8'd52);
        else if (v == 6'd62)
            return CHAR_PLUS;
        else
            return CHAR_SLASH;
    endfunction

    function automatic logic [7:0] group_char(input group_t g, input logic [2:0] slot);
        logic [7:0] c;
        case (slot)
            SLOT_SYM0: c = b64_symbol(g.e0[7:2]);
            SLOT_SYM1: c = b64_symbol({g.e0[1:0], g.e1[7:4]});
            SLOT_SYM2: c = (g.nbytes < 2'd2) ? CHAR_PAD : b64_symbol({g.e1[3:0], g.e2[7:6]});
            SLOT_SYM3: c = (g.nbytes < 2'd3) ? CHAR_PAD : b64_symbol(g.e2[5:0]);
            SLOT_CR:   c = CHAR_CR;
            SLOT_LF:   c = CHAR_LF;
            default:   c = CHAR_PAD;
        endcase
        return c;
    endfunction

endpackage

/* hdl/b64lw_queue.sv */
// ----------------------------------------------------------------------------
// b64lw_queue
// Short group queue between the byte front end and the character back end.
// ----------------------------------------------------------------------------
`include "base64_line_wrapped_encoder_macros.svh"

module b64lw_queue
    import b64lw_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  group_t        push_data,
    input  logic          pop,
    output group_t        pop_data,
    output queue_status_t status
);

    group_t                mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0]   count_reg, count_next;

    localparam logic [QUEUE_AW-1:0] PTR_LAST  = QUEUE_AW'(QUEUE_DEPTH - 1);
    localparam logic [QUEUE_CW-1:0] COUNT_MAX = QUEUE_CW'(QUEUE_DEPTH);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data     = mem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == COUNT_MAX);
    assign status.empty = (count_reg == '0);

    `B64LW_ASSERT(a_count_bound, count_reg <= COUNT_MAX, "queue count above depth")
    `B64LW_ASSERT(a_no_push_full, push |-> !status.full, "push into full queue")
    `B64LW_ASSERT(a_no_pop_empty, pop |-> !status.empty, "pop from empty queue")

endmodule

/* hdl/b64lw_front.sv */
// ----------------------------------------------------------------------------
// b64lw_front
// Collects input bytes into groups, tracks line position, holds the register.
// ----------------------------------------------------------------------------
module b64lw_front
    import b64lw_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,      // [7:0] data_byte
    input  logic          s_tlast,      // final_byte
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [4:0]    cfg_data,     // [4:0] groups_per_line
    input  queue_status_t q_status,
    output logic          push,
    output group_t        push_data
);

    logic [7:0] pend0_reg, pend0_next;
    logic [7:0] pend1_reg, pend1_next;
    logic [1:0] pcount_reg, pcount_next;
    logic [4:0] lgc_reg, lgc_next;
    logic [4:0] gpl_reg;
    logic       accept;
    logic [4:0] lgc_inc;

    assign s_tready  = !q_status.full;
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;
    assign push      = accept && (s_tlast || (pcount_reg == 2'd2));
    assign lgc_inc   = lgc_reg + 5'd1;

    always_comb
    begin
        push_data.nbytes = pcount_reg + 2'd1;
        push_data.e0     = (pcount_reg != 2'd0) ? pend0_reg : s_tdata;
        push_data.e1     = (pcount_reg == 2'd2) ? pend1_reg :
                           ((pcount_reg == 2'd1) ? s_tdata : 8'd0);
        push_data.e2     = (pcount_reg == 2'd2) ? s_tdata : 8'd0;
        push_data.crlf   = (lgc_inc == gpl_reg);
        push_data.last   = s_tlast;
    end

    always_comb
    begin
        pend0_next  = pend0_reg;
        pend1_next  = pend1_reg;
        pcount_next = pcount_reg;
        lgc_next    = lgc_reg;
        if (push)
        begin
            pcount_next = 2'd0;
            lgc_next    = (s_tlast || push_data.crlf) ? 5'd0 : lgc_inc;
        end
        else if (accept)
        begin
            // hold the byte until its group completes
            if (pcount_reg == 2'd0)
            begin
                pend0_next = s_tdata;
            end
            else
            begin
                pend1_next = s_tdata;
            end
            pcount_next = pcount_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcount_reg <= 2'd0;
            lgc_reg    <= 5'd0;
            gpl_reg    <= GROUPS_PER_LINE_RESET;
        end
        else
        begin
            pcount_reg <= pcount_next;
            lgc_reg    <= lgc_next;
            if (cfg_valid && cfg_ready)
            begin
                gpl_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend0_reg <= pend0_next;
        pend1_reg <= pend1_next;
    end

endmodule

/* hdl/b64lw_back.sv */
// ----------------------------------------------------------------------------
// b64lw_back
// Emits queued group characters into an output stage, one per cycle unless stalled.
// ----------------------------------------------------------------------------
`include "base64_line_wrapped_encoder_macros.svh"

module b64lw_back
    import b64lw_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  group_t        head,
    input  queue_status_t q_status,
    output logic          pop,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [7:0]    m_tdata,      // [7:0] out_char
    output logic          m_tlast,      // run_last
    output logic          m_tuser       // [0] stream_done
);

    logic [2:0] slot_reg, slot_next;
    logic       valid_reg, valid_next;
    logic [7:0] char_reg, char_next;
    logic       last_reg, last_next;
    logic       done_reg, done_next;
    logic       advance;
    logic       end_slot;

    assign advance  = !q_status.empty && (!valid_reg || m_tready);
    assign end_slot = (slot_reg == (head.crlf ? SLOT_LF : SLOT_SYM3));
    assign pop      = advance && end_slot;

    always_comb
    begin
        slot_next  = slot_reg;
        valid_next = valid_reg;
        char_next  = char_reg;
        last_next  = last_reg;
        done_next  = done_reg;
        if (advance)
        begin
            valid_next = 1'b1;
            char_next  = group_char(head, slot_reg);
            last_next  = end_slot;
            done_next  = end_slot && head.last;
            slot_next  = end_slot ? SLOT_SYM0 : slot_reg + 3'd1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg  <= SLOT_SYM0;
            valid_reg <= 1'b0;
        end
        else
        begin
            slot_reg  <= slot_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        last_reg <= last_next;
        done_reg <= done_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = char_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = done_reg;

    `B64LW_ASSERT(a_done_is_last, m_tvalid && m_tuser |-> m_tlast, "stream end not on run end")
    `B64LW_ASSERT(a_mid_group_head, slot_reg != SLOT_SYM0 |-> !q_status.empty, "group lost mid-emission")
    `B64LW_ASSERT(a_pop_rewinds, pop |=> slot_reg == SLOT_SYM0, "slot not rewound after pop")

endmodule

/* hdl/base64_line_wrapped_encoder.sv */
// ----------------------------------------------------------------------------
// base64_line_wrapped_encoder
// Byte stream to base64 text with CR LF after a set number of groups.
// ----------------------------------------------------------------------------
//  channel   dir  handshake            payload
//  s_*       in   s_tvalid/s_tready    tdata[7:0] data_byte, tlast final_byte
//  m_*       out  m_tvalid/m_tready    tdata[7:0] out_char, tlast run_last,
//                                      tuser[0] stream_done
//  cfg_*     in   cfg_valid/cfg_ready  cfg_data[4:0] groups_per_line
//
//  One character leaves per cycle from the single output stage while the
//  output is not stalled; a three-byte group gives four characters, or six
//  with a line break. The byte that completes a group is written to the queue,
//  and the group's first character then goes through the output stage register.
//  The input takes a byte each cycle while the two-entry group queue has room.
//  Reset clears the pending count, the line position and the queue; the
//  register returns to 19. A stall on the output holds the current character.
// ----------------------------------------------------------------------------
module base64_line_wrapped_encoder
    import b64lw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,     // [7:0] data_byte
    input  logic       s_tlast,     // final_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,     // [7:0] out_char
    output logic       m_tlast,     // run_last
    output logic       m_tuser,     // [0] stream_done
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [4:0] cfg_data     // [4:0] groups_per_line
);

    queue_status_t q_status;
    logic          push;
    logic          pop;
    group_t        push_data;
    group_t        head;

    b64lw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q_status  (q_status),
        .push      (push),
        .push_data (push_data)
    );

    b64lw_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (head),
        .status    (q_status)
    );

    b64lw_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

/* sim/b64lw_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64lw_checker
// Watches the byte, character and register channels of the line-wrapped
// base64 encoder, predicts the character stream and compares every character.
// ----------------------------------------------------------------------------
module b64lw_checker
    import b64lw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tlast,
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,
    input  logic       m_tlast,
    input  logic       m_tuser,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [4:0] cfg_data,
    output int         fail_count,
    output int         chars_outstanding
);

    localparam logic [8*64-1:0] ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    typedef struct packed {
        logic [7:0] ch;
        logic       run_last;
        logic       done;
    } enc_char_t;

    enc_char_t  expected_chars [$];
    logic [7:0] held_bytes [0:1];
    logic [1:0] held_count;
    logic [4:0] line_pos;
    logic [4:0] groups_per_line;

    function automatic logic [7:0] symbol_of(input logic [5:0] v);
        return ALPHABET[8 * (63 - int'(v)) +: 8];
    endfunction

    // Fold one byte into the open group; emit the group once it closes.
    task automatic encode_byte(input logic [7:0] b, input logic fin);
        logic [7:0] e0;
        logic [7:0] e1;
        logic [7:0] e2;
        logic [1:0] nbytes;
        logic [4:0] next_pos;
        logic [7:0] chars [0:5];
        int         n;
        enc_char_t  entry;
        if (!fin && held_count < 2'd2)
        begin
            held_bytes[held_count[0]] = b;
            held_count = held_count + 2'd1;
        end
        else
        begin
            nbytes = held_count + 2'd1;
            e0 = (held_count >= 2'd1) ? held_bytes[0] : b;
            e1 = (held_count == 2'd2) ? held_bytes[1] : ((held_count == 2'd1) ? b : 8'h00);
            e2 = (held_count == 2'd2) ? b : 8'h00;
            chars[0] = symbol_of(e0[7:2]);
            chars[1] = symbol_of({e0[1:0], e1[7:4]});
            chars[2] = (nbytes < 2'd2) ? CHAR_PAD : symbol_of({e1[3:0], e2[7:6]});
            chars[3] = (nbytes < 2'd3) ? CHAR_PAD : symbol_of(e2[5:0]);
            n = 4;
            next_pos = line_pos + 5'd1;
            if (next_pos == groups_per_line)
            begin
                chars[4] = CHAR_CR;
                chars[5] = CHAR_LF;
                n = 6;
                next_pos = 5'd0;
            end
            line_pos = fin ? 5'd0 : next_pos;
            held_count = 2'd0;
            held_bytes[0] = 8'h00;
            held_bytes[1] = 8'h00;
            for (int k = 0; k < n; k++)
            begin
                entry = {chars[k], (k == n - 1), (k == n - 1) && fin};
                expected_chars.push_back(entry);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        enc_char_t want;
        if (!rst_n)
        begin
            expected_chars.delete();
            held_bytes[0] = 8'h00;
            held_bytes[1] = 8'h00;
            held_count = 2'd0;
            line_pos = 5'd0;
            groups_per_line = GROUPS_PER_LINE_RESET;
            fail_count = 0;
            chars_outstanding = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                groups_per_line = cfg_data;
            if (s_tvalid && s_tready)
                encode_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
            begin
                if (expected_chars.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected char %h last %b done %b", m_tdata, m_tlast,
                                 m_tuser);
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (m_tdata !== want.ch || m_tlast !== want.run_last
                        || m_tuser !== want.done)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("char mismatch: expected %h/%b/%b got %h/%b/%b",
                                     want.ch, want.run_last, want.done,
                                     m_tdata, m_tlast, m_tuser);
                    end
                end
            end
            chars_outstanding = expected_chars.size();
        end
    end

endmodule

/* sim/tb_base64_line_wrapped_encoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_base64_line_wrapped_encoder
// Drives byte streams and line-length settings into the encoder with random
// gaps and output stalls; the checker beside the block judges every character.
// ----------------------------------------------------------------------------
module tb_base64_line_wrapped_encoder;

    localparam int QUIET_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 360;

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       s_tvalid  = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata   = 8'h00;
    logic       s_tlast   = 1'b0;
    logic       m_tvalid;
    logic       m_tready  = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic       m_tuser;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [4:0] cfg_data  = 5'd0;

    int fail_count;
    int chars_outstanding;
    int quiet_cycles = 0;
    int send_calm    = 0;
    int recv_calm    = 0;
    int bytes_sent   = 0;

    base64_line_wrapped_encoder i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    b64lw_checker i_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .s_tlast           (s_tlast),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .m_tlast           (m_tlast),
        .m_tuser           (m_tuser),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .fail_count        (fail_count),
        .chars_outstanding (chars_outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Mostly a random wait, with occasional calm stretches of no waiting.
    function automatic int draw_wait(inout int calm_left);
        if (calm_left == 0 && $urandom_range(0, 99) < 6)
            calm_left = $urandom_range(10, 40);
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        return $urandom_range(0, 17);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic fin);
        int w;
        w = draw_wait(send_calm);
        if (w > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (w) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= fin;
        do @(posedge clk); while (!s_tready);
        bytes_sent++;
    endtask

    // Drop the input, then hold until every predicted character is out.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (chars_outstanding != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_line_len(input logic [4:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Random streams: mostly short, some long enough to wrap lines, with a
    // few stray end-of-stream flags mixed in.
    task automatic random_bytes(input int count);
        int run_left;
        logic fin;
        run_left = 0;
        for (int i = 0; i < count; i++)
        begin
            if (run_left == 0)
                run_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 100)
                                                      : $urandom_range(1, 9);
            run_left--;
            fin = (run_left == 0) || ($urandom_range(0, 24) == 0);
            if (fin)
                run_left = 0;
            send_byte(8'($urandom_range(0, 255)), fin);
        end
    endtask

    initial
    begin
        logic [4:0] len;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every group size closed by the flag, full groups unflagged, break each group.
        write_line_len(5'd1);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b1);
        send_byte(8'hFB, 1'b0);
        send_byte(8'hEF, 1'b0);
        send_byte(8'hBE, 1'b0);
        send_byte(8'h7F, 1'b1);
        drain();

        // Line length lowered below the current position: counter wraps.
        write_line_len(5'd31);
        for (int i = 0; i < 31; i++)
            send_byte(8'($urandom_range(0, 255)), 1'b0);
        drain();
        write_line_len(5'd3);
        for (int i = 0; i < 80; i++)
            send_byte(8'($urandom_range(0, 255)), i == 79);
        drain();

        // Zero wraps the 5-bit counter: break after every 32 groups.
        write_line_len(5'd0);
        for (int i = 0; i < 100; i++)
            send_byte(8'($urandom_range(0, 255)), i == 99);
        drain();

        write_line_len(5'd19);
        random_bytes(40);
        drain();
        write_line_len(5'd2);
        random_bytes(40);
        drain();

        while (bytes_sent < RANDOM_ITEMS)
        begin
            len = 5'($urandom_range(0, 31));
            write_line_len(len);
            random_bytes((len == 5'd0 || len > 5'd20) ? 100 : 40);
            drain();
        end

        repeat (20) @(posedge clk);
        if (fail_count == 0 && chars_outstanding == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        int w;
        @(posedge rst_n);
        forever
        begin
            w = draw_wait(recv_calm);
            if (w > 0)
            begin
                m_tready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

endmodule
